// File: hdl/direct_mapped_writeback_cache_defines.svh
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_defines
// assertion macros used by the port checker of the cache
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// same-cycle implication
`define DMWC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dmwc port check failed");

// next-cycle implication
`define DMWC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dmwc port check failed");

`endif

// File: hdl/dmwc_pkg.sv
// ----------------------------------------------------------------------------
// dmwc_pkg
// types and codes shared by the direct-mapped write-back cache modules
// ----------------------------------------------------------------------------
`default_nettype none

package dmwc_pkg;

    localparam logic REQ_CPU  = 1'b0;
    localparam logic REQ_FILL = 1'b1;

    typedef enum logic [1:0] {
        KIND_CPU       = 2'd0,
        KIND_WRITEBACK = 2'd1,
        KIND_REFILL    = 2'd2,
        KIND_REJECT    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_REJECT,
        OP_HIT_READ,
        OP_HIT_WRITE,
        OP_MISS,
        OP_FILL_READ,
        OP_FILL_WRITE
    } op_code_t;

    typedef struct packed {
        op_code_t code;
        logic     writeback;
    } op_ctl_t;

    typedef enum logic [1:0] {
        F_CLEAR,
        F_IDLE,
        F_CLASSIFY
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FIRST,
        B_SECOND
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/direct_mapped_writeback_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// direct-mapped write-back write-allocate cache with whole-line accesses
//
//   channel  prefix  direction  carries
//   input    s_      in         cpu access or memory refill data
//   result   m_      out        cpu response, write-back, refill read, reject
//
// a transaction is accepted, classified against the tag memory the next cycle
// and queued; the back pops it, reads the data memory into a register and
// then loads its first result into the result register; a dirty miss adds a
// second result for its refill read. the front takes no new transaction until
// the last one is classified and queued, as the tag memory read is registered;
// the back carries out one operation at a time. after reset the tag memory is
// cleared with s_ready low. m_ready low holds the result register; a full queue
// holds the front in classification.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_writeback_cache
    import dmwc_pkg::*;
#(
    parameter int LINES        = 64,
    parameter int ADDRESS_BITS = 32,
    parameter int LINE_WIDTH   = 64,
    parameter int OFFSET_BITS  = 3
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     s_req_type,
    input  wire  [ADDRESS_BITS-1:0] s_addr,
    input  wire                     s_write_enable,
    input  wire  [LINE_WIDTH-1:0]   s_write_data,
    input  wire  [LINE_WIDTH-1:0]   s_fill_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [1:0]              m_kind,
    output logic                    m_hit,
    output logic [LINE_WIDTH-1:0]   m_read_data,
    output logic [ADDRESS_BITS-1:0] m_mem_addr,
    output logic [LINE_WIDTH-1:0]   m_mem_data,
    output logic                    m_last
);

    localparam int INDEX_BITS = $clog2(LINES + 1) - 1;
    localparam int Q_W = $bits(op_ctl_t) + INDEX_BITS + LINE_WIDTH + 2 * ADDRESS_BITS;

    logic                    push;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_pop;
    op_ctl_t                 f_ctl;
    logic [INDEX_BITS-1:0]   f_index;
    logic [LINE_WIDTH-1:0]   f_data;
    logic [ADDRESS_BITS-1:0] f_addr_a;
    logic [ADDRESS_BITS-1:0] f_addr_b;
    op_ctl_t                 b_ctl;
    logic [INDEX_BITS-1:0]   b_index;
    logic [LINE_WIDTH-1:0]   b_data;
    logic [ADDRESS_BITS-1:0] b_addr_a;
    logic [ADDRESS_BITS-1:0] b_addr_b;
    logic [Q_W-1:0]          q_in;
    logic [Q_W-1:0]          q_out;

    assign q_in = {f_ctl, f_index, f_data, f_addr_a, f_addr_b};
    assign {b_ctl, b_index, b_data, b_addr_a, b_addr_b} = q_out;

    dmwc_front #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LINE_WIDTH   (LINE_WIDTH),
        .OFFSET_BITS  (OFFSET_BITS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_addr         (s_addr),
        .s_write_enable (s_write_enable),
        .s_write_data   (s_write_data),
        .s_fill_data    (s_fill_data),
        .q_full         (q_full),
        .q_push         (push),
        .q_ctl          (f_ctl),
        .q_index        (f_index),
        .q_data         (f_data),
        .q_addr_a       (f_addr_a),
        .q_addr_b       (f_addr_b)
    );

    dmwc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    dmwc_back #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LINE_WIDTH   (LINE_WIDTH),
        .INDEX_BITS   (INDEX_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_ctl       (b_ctl),
        .q_index     (b_index),
        .q_data      (b_data),
        .q_addr_a    (b_addr_a),
        .q_addr_b    (b_addr_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_hit       (m_hit),
        .m_read_data (m_read_data),
        .m_mem_addr  (m_mem_addr),
        .m_mem_data  (m_mem_data),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

// File: hdl/dmwc_front.sv
// ----------------------------------------------------------------------------
// dmwc_front
// accepts transactions, owns tag/valid/dirty memory and the pending miss,
// classifies each transaction and pushes an operation to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module dmwc_front
    import dmwc_pkg::*;
#(
    parameter int ADDRESS_BITS = 32,
    parameter int LINE_WIDTH   = 64,
    parameter int OFFSET_BITS  = 3,
    parameter int INDEX_BITS   = 6
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     s_req_type,
    input  wire  [ADDRESS_BITS-1:0] s_addr,
    input  wire                     s_write_enable,
    input  wire  [LINE_WIDTH-1:0]   s_write_data,
    input  wire  [LINE_WIDTH-1:0]   s_fill_data,
    input  wire                     q_full,
    output logic                    q_push,
    output op_ctl_t                 q_ctl,
    output logic [INDEX_BITS-1:0]   q_index,
    output logic [LINE_WIDTH-1:0]   q_data,
    output logic [ADDRESS_BITS-1:0] q_addr_a,
    output logic [ADDRESS_BITS-1:0] q_addr_b
);

    localparam int SHIFT = OFFSET_BITS + INDEX_BITS;
    localparam int TAG_W = (ADDRESS_BITS > SHIFT) ? (ADDRESS_BITS - SHIFT) : 1;
    localparam int EXT_W = SHIFT + TAG_W;
    localparam int DEPTH = 1 << INDEX_BITS;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } tag_entry_t;

    function automatic logic [ADDRESS_BITS-1:0] line_addr(
        input logic [TAG_W-1:0]      t,
        input logic [INDEX_BITS-1:0] i
    );
        logic [EXT_W-1:0] ext;
        ext = (EXT_W'(t) << SHIFT) | (EXT_W'(i) << OFFSET_BITS);
        return ext[ADDRESS_BITS-1:0];
    endfunction

    tag_entry_t tag_mem [DEPTH];
    tag_entry_t tag_rd_reg;

    front_state_t state_reg, state_next;
    logic [INDEX_BITS-1:0] clear_cnt_reg;

    logic                  req_type_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic                  we_reg;
    logic [LINE_WIDTH-1:0] wdata_reg;
    logic [LINE_WIDTH-1:0] fdata_reg;

    logic                  miss_pending_reg, miss_pending_next;
    logic [TAG_W-1:0]      pending_tag_reg, pending_tag_next;
    logic [INDEX_BITS-1:0] pending_index_reg, pending_index_next;
    logic                  pending_write_reg, pending_write_next;
    logic [LINE_WIDTH-1:0] pending_wdata_reg, pending_wdata_next;

    logic [EXT_W-1:0]      addr_ext;
    logic [INDEX_BITS-1:0] s_idx;
    logic [TAG_W-1:0]      s_tag;
    logic                  accept;
    logic                  classify;
    logic                  clear_done;
    logic                  hit;
    logic                  tag_we;
    logic [INDEX_BITS-1:0] tag_waddr;
    tag_entry_t            tag_wdata;

    assign addr_ext   = EXT_W'(s_addr);
    assign s_idx      = addr_ext[OFFSET_BITS +: INDEX_BITS];
    assign s_tag      = addr_ext[SHIFT +: TAG_W];
    assign accept     = s_valid && s_ready;
    assign classify   = (state_reg == F_CLASSIFY) && !q_full;
    assign clear_done = (clear_cnt_reg == {INDEX_BITS{1'b1}});
    assign hit        = tag_rd_reg.valid && (tag_rd_reg.tag == tag_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_CLEAR: begin
                if (clear_done) begin
                    state_next = F_IDLE;
                end
            end
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_CLASSIFY;
                end
            end
            F_CLASSIFY: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_CLEAR;
        endcase
    end

    // outputs and classification
    always_comb begin
        s_ready            = (state_reg == F_IDLE);
        q_push             = classify;
        q_ctl              = '{code: OP_REJECT, writeback: 1'b0};
        q_index            = idx_reg;
        q_data             = wdata_reg;
        q_addr_a           = '0;
        q_addr_b           = '0;
        tag_we             = 1'b0;
        tag_waddr          = idx_reg;
        tag_wdata          = '{valid: 1'b1, dirty: 1'b1, tag: tag_reg};
        miss_pending_next  = miss_pending_reg;
        pending_tag_next   = pending_tag_reg;
        pending_index_next = pending_index_reg;
        pending_write_next = pending_write_reg;
        pending_wdata_next = pending_wdata_reg;

        unique case (state_reg)
            F_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = clear_cnt_reg;
                tag_wdata = '0;
            end
            F_CLASSIFY: begin
                if (req_type_reg == REQ_CPU) begin
                    if (miss_pending_reg) begin
                        q_ctl.code = OP_REJECT;
                    end else if (hit) begin
                        if (we_reg) begin
                            q_ctl.code = OP_HIT_WRITE;
                            tag_we     = classify;
                        end else begin
                            q_ctl.code = OP_HIT_READ;
                        end
                    end else begin
                        q_ctl.code         = OP_MISS;
                        q_ctl.writeback    = tag_rd_reg.valid && tag_rd_reg.dirty;
                        q_addr_a           = line_addr(tag_rd_reg.tag, idx_reg);
                        q_addr_b           = line_addr(tag_reg, idx_reg);
                        if (classify) begin
                            miss_pending_next  = 1'b1;
                            pending_tag_next   = tag_reg;
                            pending_index_next = idx_reg;
                            pending_write_next = we_reg;
                            pending_wdata_next = wdata_reg;
                        end
                    end
                end else begin
                    if (!miss_pending_reg) begin
                        q_ctl.code = OP_REJECT;
                    end else begin
                        q_ctl.code = pending_write_reg ? OP_FILL_WRITE : OP_FILL_READ;
                        q_data     = pending_write_reg ? pending_wdata_reg : fdata_reg;
                        q_index    = pending_index_reg;
                        tag_we     = classify;
                        tag_waddr  = pending_index_reg;
                        tag_wdata  = '{valid: 1'b1, dirty: pending_write_reg,
                                       tag: pending_tag_reg};
                        if (classify) begin
                            miss_pending_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= F_CLEAR;
            clear_cnt_reg    <= '0;
            miss_pending_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            miss_pending_reg <= miss_pending_next;
            if (state_reg == F_CLEAR) begin
                clear_cnt_reg <= clear_cnt_reg + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pending_tag_reg   <= pending_tag_next;
        pending_index_reg <= pending_index_next;
        pending_write_reg <= pending_write_next;
        pending_wdata_reg <= pending_wdata_next;
        if (accept) begin
            req_type_reg <= s_req_type;
            idx_reg      <= s_idx;
            tag_reg      <= s_tag;
            we_reg       <= s_write_enable;
            wdata_reg    <= s_write_data;
            fdata_reg    <= s_fill_data;
        end
    end

    // tag memory
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (accept) begin
            tag_rd_reg <= tag_mem[s_idx];
        end
    end

endmodule

`default_nettype wire

// File: hdl/dmwc_queue.sv
// ----------------------------------------------------------------------------
// dmwc_queue
// two-entry operation queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module dmwc_queue
    import dmwc_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  wire  [WIDTH-1:0] push_data,
    output logic             full,
    input  wire              pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dmwc_back.sv
// ----------------------------------------------------------------------------
// dmwc_back
// carries out queued operations on the line data memory and drives the
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module dmwc_back
    import dmwc_pkg::*;
#(
    parameter int ADDRESS_BITS = 32,
    parameter int LINE_WIDTH   = 64,
    parameter int INDEX_BITS   = 6
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     q_empty,
    output logic                    q_pop,
    input  wire  op_ctl_t           q_ctl,
    input  wire  [INDEX_BITS-1:0]   q_index,
    input  wire  [LINE_WIDTH-1:0]   q_data,
    input  wire  [ADDRESS_BITS-1:0] q_addr_a,
    input  wire  [ADDRESS_BITS-1:0] q_addr_b,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [1:0]              m_kind,
    output logic                    m_hit,
    output logic [LINE_WIDTH-1:0]   m_read_data,
    output logic [ADDRESS_BITS-1:0] m_mem_addr,
    output logic [LINE_WIDTH-1:0]   m_mem_data,
    output logic                    m_last
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [LINE_WIDTH-1:0] data_mem [DEPTH];
    logic [LINE_WIDTH-1:0] rd_data_reg;

    back_state_t state_reg, state_next;

    op_ctl_t               op_ctl_reg;
    logic [LINE_WIDTH-1:0] op_data_reg;
    logic [ADDRESS_BITS-1:0] addr_a_reg;
    logic [ADDRESS_BITS-1:0] addr_b_reg;

    logic                    m_valid_reg, m_valid_next;
    kind_t                   m_kind_reg;
    logic                    m_hit_reg;
    logic [LINE_WIDTH-1:0]   m_read_data_reg;
    logic [ADDRESS_BITS-1:0] m_mem_addr_reg;
    logic [LINE_WIDTH-1:0]   m_mem_data_reg;
    logic                    m_last_reg;

    logic                    out_free;
    logic                    load;
    logic                    mem_we;
    kind_t                   out_kind;
    logic                    out_hit;
    logic [LINE_WIDTH-1:0]   out_read_data;
    logic [ADDRESS_BITS-1:0] out_mem_addr;
    logic [LINE_WIDTH-1:0]   out_mem_data;
    logic                    out_last;
    logic                    two_results;

    assign out_free    = !m_valid_reg || m_ready;
    assign two_results = (op_ctl_reg.code == OP_MISS) && op_ctl_reg.writeback;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = B_FIRST;
                end
            end
            B_FIRST: begin
                if (out_free) begin
                    state_next = two_results ? B_SECOND : B_IDLE;
                end
            end
            B_SECOND: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop         = 1'b0;
        load          = 1'b0;
        out_kind      = KIND_CPU;
        out_hit       = 1'b0;
        out_read_data = '0;
        out_mem_addr  = '0;
        out_mem_data  = '0;
        out_last      = 1'b1;
        unique case (state_reg)
            B_IDLE: begin
                q_pop = !q_empty;
            end
            B_FIRST: begin
                load = out_free;
                unique case (op_ctl_reg.code)
                    OP_REJECT: begin
                        out_kind = KIND_REJECT;
                    end
                    OP_HIT_READ: begin
                        out_hit       = 1'b1;
                        out_read_data = rd_data_reg;
                    end
                    OP_HIT_WRITE: begin
                        out_hit = 1'b1;
                    end
                    OP_MISS: begin
                        if (op_ctl_reg.writeback) begin
                            out_kind     = KIND_WRITEBACK;
                            out_mem_addr = addr_a_reg;
                            out_mem_data = rd_data_reg;
                            out_last     = 1'b0;
                        end else begin
                            out_kind     = KIND_REFILL;
                            out_mem_addr = addr_b_reg;
                        end
                    end
                    OP_FILL_READ: begin
                        out_read_data = op_data_reg;
                    end
                    OP_FILL_WRITE: begin
                    end
                    default: begin
                        out_kind = KIND_REJECT;
                    end
                endcase
            end
            B_SECOND: begin
                load         = out_free;
                out_kind     = KIND_REFILL;
                out_mem_addr = addr_b_reg;
            end
            default: begin
            end
        endcase
    end

    assign mem_we = q_pop && ((q_ctl.code == OP_HIT_WRITE) || (q_ctl.code == OP_FILL_READ)
                              || (q_ctl.code == OP_FILL_WRITE));

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_ctl_reg  <= q_ctl;
            op_data_reg <= q_data;
            addr_a_reg  <= q_addr_a;
            addr_b_reg  <= q_addr_b;
        end
        if (load) begin
            m_kind_reg      <= out_kind;
            m_hit_reg       <= out_hit;
            m_read_data_reg <= out_read_data;
            m_mem_addr_reg  <= out_mem_addr;
            m_mem_data_reg  <= out_mem_data;
            m_last_reg      <= out_last;
        end
    end

    // line data memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            data_mem[q_index] <= q_data;
        end
        if (q_pop) begin
            rd_data_reg <= data_mem[q_index];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_hit       = m_hit_reg;
    assign m_read_data = m_read_data_reg;
    assign m_mem_addr  = m_mem_addr_reg;
    assign m_mem_data  = m_mem_data_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// File: hdl/dmwc_checker.sv
// ----------------------------------------------------------------------------
// dmwc_checker
// port-level checks on the result channel of the cache, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "direct_mapped_writeback_cache_defines.svh"

module dmwc_checker
    import dmwc_pkg::*;
#(
    parameter int ADDRESS_BITS = 32,
    parameter int LINE_WIDTH   = 64
) (
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    m_valid,
    input wire                    m_ready,
    input wire [1:0]              m_kind,
    input wire                    m_hit,
    input wire [LINE_WIDTH-1:0]   m_read_data,
    input wire [ADDRESS_BITS-1:0] m_mem_addr,
    input wire [LINE_WIDTH-1:0]   m_mem_data,
    input wire                    m_last
);

    `DMWC_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_mem_addr) && $stable(m_read_data))
    `DMWC_ASSERT_NOW(a_reject_clean, aclk, aresetn, m_valid && (m_kind == KIND_REJECT), m_last && !m_hit && (m_read_data == '0) && (m_mem_addr == '0) && (m_mem_data == '0))
    `DMWC_ASSERT_NOW(a_writeback_not_last, aclk, aresetn, m_valid && (m_kind == KIND_WRITEBACK), !m_last && !m_hit)
    `DMWC_ASSERT_NOW(a_mem_data_only_wb, aclk, aresetn, m_valid && (m_kind != KIND_WRITEBACK), m_mem_data == '0)
    `DMWC_ASSERT_NEXT(a_refill_follows_wb, aclk, aresetn, m_valid && m_ready && (m_kind == KIND_WRITEBACK), m_valid && (m_kind == KIND_REFILL) && m_last)

endmodule

bind direct_mapped_writeback_cache dmwc_checker #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .LINE_WIDTH   (LINE_WIDTH)
) u_dmwc_checker (.*);

`default_nettype wire

// File: dv/dmwc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dmwc_result_checker
// watches both channels of the direct-mapped write-back cache, keeps its own
// copy of the tag, valid, dirty and data stores and the open miss, predicts
// the results of every accepted transaction and compares each accepted result
// field by field with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module dmwc_result_checker
    import dmwc_pkg::*;
#(
    parameter int LINES        = 64,
    parameter int ADDRESS_BITS = 32,
    parameter int LINE_WIDTH   = 64,
    parameter int OFFSET_BITS  = 3
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    input  wire                    s_ready,
    input  wire                    s_req_type,
    input  wire [ADDRESS_BITS-1:0] s_addr,
    input  wire                    s_write_enable,
    input  wire [LINE_WIDTH-1:0]   s_write_data,
    input  wire [LINE_WIDTH-1:0]   s_fill_data,
    input  wire                    m_valid,
    input  wire                    m_ready,
    input  wire [1:0]              m_kind,
    input  wire                    m_hit,
    input  wire [LINE_WIDTH-1:0]   m_read_data,
    input  wire [ADDRESS_BITS-1:0] m_mem_addr,
    input  wire [LINE_WIDTH-1:0]   m_mem_data,
    input  wire                    m_last,
    output int                     error_count,
    output int                     results_owed,
    output logic                   fill_owed,
    output int                     hit_count,
    output int                     miss_count,
    output int                     writeback_count,
    output int                     fill_count,
    output int                     reject_count
);

    localparam int INDEX_BITS = $clog2(LINES);
    localparam int TAG_BITS   = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;

    typedef struct {
        kind_t                   kind;
        logic                    hit;
        logic [LINE_WIDTH-1:0]   read_data;
        logic [ADDRESS_BITS-1:0] mem_addr;
        logic [LINE_WIDTH-1:0]   mem_data;
        logic                    last;
    } cache_result_t;

    cache_result_t owed_results[$];

    logic [TAG_BITS-1:0]   tag_store  [LINES];
    logic                  line_valid [LINES];
    logic                  line_dirty [LINES];
    logic [LINE_WIDTH-1:0] line_data  [LINES];

    logic                  miss_open;
    logic [TAG_BITS-1:0]   miss_tag;
    logic [INDEX_BITS-1:0] miss_index;
    logic                  miss_write;
    logic [LINE_WIDTH-1:0] miss_wdata;

    assign fill_owed = miss_open;

    initial begin
        for (int i = 0; i < LINES; i++) begin
            tag_store[i]  = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_data[i]  = '0;
        end
        miss_open       = 1'b0;
        miss_tag        = '0;
        miss_index      = '0;
        miss_write      = 1'b0;
        miss_wdata      = '0;
        error_count     = 0;
        results_owed    = 0;
        hit_count       = 0;
        miss_count      = 0;
        writeback_count = 0;
        fill_count      = 0;
        reject_count    = 0;
    end

    function automatic cache_result_t make_result(
        input kind_t                   kind,
        input logic                    hit,
        input logic [LINE_WIDTH-1:0]   read_data,
        input logic [ADDRESS_BITS-1:0] mem_addr,
        input logic [LINE_WIDTH-1:0]   mem_data,
        input logic                    last
    );
        cache_result_t r;
        r.kind      = kind;
        r.hit       = hit;
        r.read_data = read_data;
        r.mem_addr  = mem_addr;
        r.mem_data  = mem_data;
        r.last      = last;
        return r;
    endfunction

    function automatic logic [ADDRESS_BITS-1:0] line_base(
        input logic [TAG_BITS-1:0]   tag,
        input logic [INDEX_BITS-1:0] idx
    );
        return {tag, idx, {OFFSET_BITS{1'b0}}};
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    task automatic apply_transaction(
        input logic                    req_type,
        input logic [ADDRESS_BITS-1:0] addr,
        input logic                    we,
        input logic [LINE_WIDTH-1:0]   wdata,
        input logic [LINE_WIDTH-1:0]   fdata
    );
        logic [INDEX_BITS-1:0] idx;
        logic [TAG_BITS-1:0]   tag;
        idx = addr[OFFSET_BITS +: INDEX_BITS];
        tag = addr[ADDRESS_BITS-1 -: TAG_BITS];
        if (req_type == REQ_CPU) begin
            if (miss_open) begin
                reject_count++;
                owed_results.push_back(make_result(KIND_REJECT, 1'b0, '0, '0, '0, 1'b1));
            end else if (line_valid[idx] && tag_store[idx] == tag) begin
                hit_count++;
                if (we) begin
                    line_data[idx]  = wdata;
                    line_dirty[idx] = 1'b1;
                    owed_results.push_back(make_result(KIND_CPU, 1'b1, '0, '0, '0, 1'b1));
                end else begin
                    owed_results.push_back(
                        make_result(KIND_CPU, 1'b1, line_data[idx], '0, '0, 1'b1));
                end
            end else begin
                miss_count++;
                miss_open  = 1'b1;
                miss_tag   = tag;
                miss_index = idx;
                miss_write = we;
                miss_wdata = wdata;
                if (line_valid[idx] && line_dirty[idx]) begin
                    writeback_count++;
                    owed_results.push_back(make_result(KIND_WRITEBACK, 1'b0, '0,
                        line_base(tag_store[idx], idx), line_data[idx], 1'b0));
                end
                owed_results.push_back(
                    make_result(KIND_REFILL, 1'b0, '0, line_base(tag, idx), '0, 1'b1));
            end
        end else if (!miss_open) begin
            reject_count++;
            owed_results.push_back(make_result(KIND_REJECT, 1'b0, '0, '0, '0, 1'b1));
        end else begin
            fill_count++;
            tag_store[miss_index]  = miss_tag;
            line_valid[miss_index] = 1'b1;
            if (miss_write) begin
                line_data[miss_index]  = miss_wdata;
                line_dirty[miss_index] = 1'b1;
                owed_results.push_back(make_result(KIND_CPU, 1'b0, '0, '0, '0, 1'b1));
            end else begin
                line_data[miss_index]  = fdata;
                line_dirty[miss_index] = 1'b0;
                owed_results.push_back(make_result(KIND_CPU, 1'b0, fdata, '0, '0, 1'b1));
            end
            miss_open = 1'b0;
        end
    endtask

    task automatic check_result();
        cache_result_t want;
        if (owed_results.size() == 0) begin
            report_error($sformatf("result of kind %0d with nothing outstanding", m_kind));
            return;
        end
        want = owed_results.pop_front();
        check_field("kind", m_kind, want.kind);
        check_field("hit", m_hit, want.hit);
        check_field("read_data", m_read_data, want.read_data);
        check_field("mem_addr", m_mem_addr, want.mem_addr);
        check_field("mem_data", m_mem_data, want.mem_data);
        check_field("last", m_last, want.last);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                apply_transaction(s_req_type, s_addr, s_write_enable, s_write_data,
                                  s_fill_data);
            end
            results_owed = owed_results.size();
        end
    end

endmodule

// File: dv/tb_direct_mapped_writeback_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_writeback_cache
// drives the cache with a directed set of hits, clean and dirty misses,
// pending writes and out-of-turn transactions, then with random traffic that
// mostly follows each miss with its refill data; both channels idle at
// random, the result side holds off once long enough to back the cache up,
// and the sender once waits for a full drain; the checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
module tb_direct_mapped_writeback_cache;
    import dmwc_pkg::*;

    localparam int LINES          = 64;
    localparam int ADDRESS_BITS   = 32;
    localparam int LINE_WIDTH     = 64;
    localparam int OFFSET_BITS    = 3;
    localparam int INDEX_BITS     = $clog2(LINES);
    localparam int TAG_BITS       = ADDRESS_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int ITEM_COUNT     = 850;
    localparam int MAX_GAP        = 17;
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_AT       = 550;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_req_type = REQ_CPU;
    logic [ADDRESS_BITS-1:0] s_addr = '0;
    logic                    s_write_enable = 1'b0;
    logic [LINE_WIDTH-1:0]   s_write_data = '0;
    logic [LINE_WIDTH-1:0]   s_fill_data = '0;
    logic                    m_ready = 1'b0;

    wire                     s_ready;
    wire                     m_valid;
    wire  [1:0]              m_kind;
    wire                     m_hit;
    wire  [LINE_WIDTH-1:0]   m_read_data;
    wire  [ADDRESS_BITS-1:0] m_mem_addr;
    wire  [LINE_WIDTH-1:0]   m_mem_data;
    wire                     m_last;

    int   error_count;
    int   results_owed;
    logic fill_owed;
    int   hit_count;
    int   miss_count;
    int   writeback_count;
    int   fill_count;
    int   reject_count;

    int   sent_count = 0;
    int   idle_cycles = 0;
    bit   hold_requested = 1'b0;
    bit   hold_finished = 1'b0;

    logic [TAG_BITS-1:0] hot_tags [4];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    direct_mapped_writeback_cache #(
        .LINES        (LINES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LINE_WIDTH   (LINE_WIDTH),
        .OFFSET_BITS  (OFFSET_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_addr         (s_addr),
        .s_write_enable (s_write_enable),
        .s_write_data   (s_write_data),
        .s_fill_data    (s_fill_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_hit          (m_hit),
        .m_read_data    (m_read_data),
        .m_mem_addr     (m_mem_addr),
        .m_mem_data     (m_mem_data),
        .m_last         (m_last)
    );

    dmwc_result_checker #(
        .LINES        (LINES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LINE_WIDTH   (LINE_WIDTH),
        .OFFSET_BITS  (OFFSET_BITS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_addr          (s_addr),
        .s_write_enable  (s_write_enable),
        .s_write_data    (s_write_data),
        .s_fill_data     (s_fill_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_hit           (m_hit),
        .m_read_data     (m_read_data),
        .m_mem_addr      (m_mem_addr),
        .m_mem_data      (m_mem_data),
        .m_last          (m_last),
        .error_count     (error_count),
        .results_owed    (results_owed),
        .fill_owed       (fill_owed),
        .hit_count       (hit_count),
        .miss_count      (miss_count),
        .writeback_count (writeback_count),
        .fill_count      (fill_count),
        .reject_count    (reject_count)
    );

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [LINE_WIDTH-1:0] rand_line();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDRESS_BITS-1:0] pick_cpu_addr();
        logic [TAG_BITS-1:0]   tag;
        logic [INDEX_BITS-1:0] idx;
        logic [OFFSET_BITS-1:0] offset;
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        tag    = hot_tags[$urandom_range(0, 3)];
        idx    = ($urandom_range(0, 3) == 0) ? INDEX_BITS'($urandom_range(0, LINES - 1))
                                             : INDEX_BITS'($urandom_range(0, 7));
        offset = OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1));
        return {tag, idx, offset};
    endfunction

    task automatic send_item(
        input logic                    req_type,
        input logic [ADDRESS_BITS-1:0] addr,
        input logic                    we,
        input logic [LINE_WIDTH-1:0]   wdata,
        input logic [LINE_WIDTH-1:0]   fdata,
        input int                      gap
    );
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type     <= req_type;
        s_addr         <= addr;
        s_write_enable <= we;
        s_write_data   <= wdata;
        s_fill_data    <= fdata;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int gap;
        int served;
        bit calm;
        served = 0;
        calm   = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (served % 32 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            served++;
            if (hold_requested && !hold_finished) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_finished = 1'b1;
            end else begin
                gap = draw_gap(calm);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        int  gap;
        bit  calm;
        bit  send_fill;
        calm = 1'b0;
        hot_tags[0] = '0;
        hot_tags[1] = '1;
        hot_tags[2] = TAG_BITS'($urandom);
        hot_tags[3] = TAG_BITS'($urandom);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // invalid line miss, access during a miss, fills and hits
        send_item(REQ_CPU,  32'h0000_0000, 1'b0, '0, '0, draw_gap(calm));
        send_item(REQ_CPU,  32'h1234_5678, 1'b1, '1, '0, draw_gap(calm));
        send_item(REQ_FILL, 32'h0000_0000, 1'b0, '0, '1, draw_gap(calm));
        send_item(REQ_CPU,  32'h0000_0007, 1'b0, '0, '0, draw_gap(calm));
        send_item(REQ_CPU,  32'h0000_0000, 1'b1, '0, '1, draw_gap(calm));
        send_item(REQ_CPU,  32'hFFFF_FFFF, 1'b0, '1, '1, draw_gap(calm));
        send_item(REQ_FILL, 32'hFFFF_FFFF, 1'b1, '1, '0, draw_gap(calm));
        send_item(REQ_CPU,  32'hFFFF_FFF8, 1'b0, '0, '0, draw_gap(calm));
        // write miss on a clean line, then dirty victims
        send_item(REQ_CPU,  32'h0000_01F8, 1'b1, 64'h0123_4567_89AB_CDEF, '0,
                  draw_gap(calm));
        send_item(REQ_FILL, 32'h0000_0000, 1'b0, '0, '1, draw_gap(calm));
        send_item(REQ_CPU,  32'hFFFF_FE00, 1'b0, '0, '0, draw_gap(calm));
        send_item(REQ_FILL, 32'h0000_0000, 1'b0, '0, 64'hA5A5_A5A5_A5A5_A5A5,
                  draw_gap(calm));
        send_item(REQ_FILL, 32'hFFFF_FFFF, 1'b1, '1, '1, draw_gap(calm));
        send_item(REQ_CPU,  32'hFFFF_FFF8, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A, '1,
                  draw_gap(calm));
        send_item(REQ_FILL, 32'h0000_0000, 1'b0, '0, '0, draw_gap(calm));
        send_item(REQ_CPU,  32'hFFFF_FFFF, 1'b0, '0, '0, draw_gap(calm));
        send_item(REQ_CPU,  32'hFFFF_FE05, 1'b1, '1, '0, draw_gap(calm));
        send_item(REQ_CPU,  32'h0000_0000, 1'b0, '0, '0, draw_gap(calm));
        send_item(REQ_FILL, 32'h0000_0000, 1'b0, '0, 64'h8000_0000_0000_0001,
                  draw_gap(calm));
        send_item(REQ_CPU,  32'h0000_0000, 1'b0, '0, '0, draw_gap(calm));

        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % 32 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n == HOLD_AT) begin
                hold_requested = 1'b1;
            end
            if (n == DRAIN_AT) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (results_owed != 0);
            end
            gap = (hold_requested && !hold_finished) ? 0 : draw_gap(calm);
            // mostly well-formed: a fill answers each open miss
            send_fill = fill_owed ? ($urandom_range(0, 9) != 0)
                                  : ($urandom_range(0, 14) == 0);
            if (send_fill) begin
                send_item(REQ_FILL, $urandom, 1'($urandom_range(0, 1)), rand_line(),
                          rand_line(), gap);
            end else begin
                send_item(REQ_CPU, pick_cpu_addr(), 1'($urandom_range(0, 1)),
                          rand_line(), rand_line(), gap);
            end
        end
        s_valid <= 1'b0;

        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("%0d input transactions, with a %0d-cycle result hold-off and a full drain",
                 sent_count, HOLD_CYCLES);
        $display("%0d hits, %0d misses, %0d write-backs, %0d fills, %0d rejects",
                 hit_count, miss_count, writeback_count, fill_count, reject_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/dmwc_pkg.sv
hdl/dmwc_front.sv
hdl/dmwc_queue.sv
hdl/dmwc_back.sv
hdl/direct_mapped_writeback_cache.sv
hdl/dmwc_checker.sv
dv/dmwc_result_checker.sv
dv/tb_direct_mapped_writeback_cache.sv
